FILE: rtl/core/qbv_pkg.sv
`timescale 1ns / 1ps

package qbv_pkg;

   // input and output formats
   localparam int IN_WIDTH  = 16;
   localparam int FRAC_BITS = 14;
   localparam int UNIT_BITS = 30;
   localparam int W_WIDTH   = 15;
   localparam int C_WIDTH   = 16;

   // internal widths
   localparam int COMP_WIDTH  = 33;
   localparam int MAG_WIDTH   = 32;
   localparam int UNIT_WIDTH  = 32;
   localparam int SQ_WIDTH    = 64;
   localparam int ROOT_WIDTH  = SQ_WIDTH / 2;
   localparam int QUO_WIDTH   = 31;
   localparam int SHIFT_WIDTH = 5;
   localparam int DEN_SHIFT   = UNIT_BITS - FRAC_BITS;
   localparam int W_SHIFT     = UNIT_BITS + 1 - FRAC_BITS;
   localparam int DEN_WIDTH   = ROOT_WIDTH + DEN_SHIFT + 1;

   // pipeline depths
   localparam int ISQRT_LAT  = ROOT_WIDTH;
   localparam int DIV_LAT    = QUO_WIDTH;
   localparam int UNIT_FRONT = 6;
   localparam int LAT_UNIT   = UNIT_FRONT + ISQRT_LAT + 1 + DIV_LAT + 1;
   localparam int LAT_NORM   = ISQRT_LAT + 1 + DIV_LAT + 1;
   localparam int LAT_BRANCH = LAT_UNIT + 1;
   localparam int PAD_NORM   = LAT_BRANCH - LAT_NORM;
   localparam int LAT_FRONT  = 1 + LAT_UNIT + 3;
   localparam int LAT_TOTAL  = LAT_FRONT + LAT_BRANCH;

   // numeric constants
   localparam logic [63:0] UNIT_ONE      = 64'd1 << UNIT_BITS;
   localparam logic [63:0] COS_HALF      = 64'd1 << (UNIT_BITS - 1);
   localparam logic [63:0] OPP_MARGIN    = 64'd1073742;
   localparam logic [63:0] AXIS_MIN_LEN2 = 64'd11529215046068470;
   localparam logic [31:0] SAT_LIM       = 32'd1 << FRAC_BITS;
   localparam logic [31:0] OPP_HALF      = 32'((64'd1 << DEN_SHIFT) >> 1);
   localparam logic [32:0] W_HALF        = 33'd1 << (W_SHIFT - 1);

   typedef logic signed [COMP_WIDTH-1:0] comp_type;
   typedef logic signed [UNIT_WIDTH-1:0] unit_type;
   typedef logic [2:0][63:0] cross_type;

   typedef struct packed {
      logic [2:0][MAG_WIDTH-1:0] mag;
      logic [2:0]                neg;
      logic                      zero;
   } unit_side_type;

   typedef struct packed {
      logic opp;
      logic degen;
   } flag_type;

   typedef struct packed {
      logic [W_WIDTH-1:0] w;
      logic [2:0]         neg;
   } norm_side_type;

   typedef struct packed {
      logic [W_WIDTH-1:0]      w;
      logic [2:0][C_WIDTH-1:0] c;
   } quat_type;

endpackage

FILE: rtl/core/qbv_isqrt.sv
`timescale 1ns / 1ps

module qbv_isqrt import qbv_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic [SQ_WIDTH-1:0]   radicand,
   output logic [ROOT_WIDTH-1:0] root
);

   logic [SQ_WIDTH-1:0] rem_ff  [ISQRT_LAT];
   logic [SQ_WIDTH-1:0] res_ff  [ISQRT_LAT];
   logic [SQ_WIDTH-1:0] rem_in  [ISQRT_LAT];
   logic [SQ_WIDTH-1:0] res_in  [ISQRT_LAT];
   logic [SQ_WIDTH-1:0] rem_src [ISQRT_LAT];
   logic [SQ_WIDTH-1:0] res_src [ISQRT_LAT];

   // stage inputs
   always_comb begin
      rem_src[0] = radicand;
      res_src[0] = '0;
      for (int j = 1; j < ISQRT_LAT; j++) begin
         rem_src[j] = rem_ff[j-1];
         res_src[j] = res_ff[j-1];
      end
   end

   // one result bit per stage
   always_comb begin
      logic [SQ_WIDTH-1:0] bit_val;
      logic [SQ_WIDTH-1:0] trial;
      for (int j = 0; j < ISQRT_LAT; j++) begin
         bit_val = SQ_WIDTH'(1) << (SQ_WIDTH - 2 - 2 * j);
         trial   = res_src[j] + bit_val;
         if (rem_src[j] >= trial) begin
            rem_in[j] = rem_src[j] - trial;
            res_in[j] = (res_src[j] >> 1) + bit_val;
         end else begin
            rem_in[j] = rem_src[j];
            res_in[j] = res_src[j] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < ISQRT_LAT; j++) begin
            rem_ff[j] <= rem_in[j];
            res_ff[j] <= res_in[j];
         end
      end
   end

   assign root = res_ff[ISQRT_LAT-1][ROOT_WIDTH-1:0];

endmodule

FILE: rtl/core/qbv_div.sv
`timescale 1ns / 1ps

module qbv_div import qbv_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [SQ_WIDTH-1:0]  numer,
   input  logic [DEN_WIDTH-1:0] denom,
   output logic [QUO_WIDTH-1:0] quot
);

   localparam int TRIAL_WIDTH = DEN_WIDTH + QUO_WIDTH;

   logic [SQ_WIDTH-1:0]  rem_ff  [DIV_LAT];
   logic [DEN_WIDTH-1:0] den_ff  [DIV_LAT];
   logic [QUO_WIDTH-1:0] quo_ff  [DIV_LAT];
   logic [SQ_WIDTH-1:0]  rem_in  [DIV_LAT];
   logic [QUO_WIDTH-1:0] quo_in  [DIV_LAT];
   logic [SQ_WIDTH-1:0]  rem_src [DIV_LAT];
   logic [DEN_WIDTH-1:0] den_src [DIV_LAT];
   logic [QUO_WIDTH-1:0] quo_src [DIV_LAT];

   // stage inputs
   always_comb begin
      rem_src[0] = numer;
      den_src[0] = denom;
      quo_src[0] = '0;
      for (int j = 1; j < DIV_LAT; j++) begin
         rem_src[j] = rem_ff[j-1];
         den_src[j] = den_ff[j-1];
         quo_src[j] = quo_ff[j-1];
      end
   end

   // restoring division, quotient msb first
   always_comb begin
      logic [TRIAL_WIDTH-1:0] trial;
      logic [TRIAL_WIDTH-1:0] rem_x;
      for (int j = 0; j < DIV_LAT; j++) begin
         trial = TRIAL_WIDTH'(den_src[j]) << (QUO_WIDTH - 1 - j);
         rem_x = TRIAL_WIDTH'(rem_src[j]);
         if (rem_x >= trial) begin
            rem_in[j] = SQ_WIDTH'(rem_x - trial);
            quo_in[j] = {quo_src[j][QUO_WIDTH-2:0], 1'b1};
         end else begin
            rem_in[j] = rem_src[j];
            quo_in[j] = {quo_src[j][QUO_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < DIV_LAT; j++) begin
            rem_ff[j] <= rem_in[j];
            den_ff[j] <= den_src[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign quot = quo_ff[DIV_LAT-1];

endmodule

FILE: rtl/core/qbv_unitize.sv
`timescale 1ns / 1ps

module qbv_unitize import qbv_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  comp_type comp [3],
   output unit_type unit [3],
   output logic     zero
);

   unit_side_type         s0_ff, s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   unit_side_type         s0_in, s1_in, s3_in;
   logic [MAG_WIDTH-1:0]  mx1_ff, mx1_in;
   logic [SHIFT_WIDTH-1:0] k2_ff, k2_in;
   logic [SQ_WIDTH-1:0]   sq4_ff [3];
   logic [SQ_WIDTH-1:0]   sum5_ff;
   unit_side_type         sd_ff [ISQRT_LAT];
   logic [ROOT_WIDTH-1:0] root;
   logic [SQ_WIDTH-1:0]   num6_ff [3];
   logic [DEN_WIDTH-1:0]  den6_ff;
   logic [3:0]            fl6_ff;
   logic [3:0]            fd_ff [DIV_LAT];
   logic [QUO_WIDTH-1:0]  quo [3];
   unit_type              unit_ff [3];
   logic                  zero_ff;

   // magnitudes and signs
   always_comb begin
      s0_in = '0;
      for (int i = 0; i < 3; i++) begin
         s0_in.neg[i] = comp[i] < 0;
         s0_in.mag[i] = MAG_WIDTH'(comp[i] < 0 ? -comp[i] : comp[i]);
      end
   end

   // largest magnitude
   always_comb begin
      mx1_in = s0_ff.mag[0];
      if (s0_ff.mag[1] > mx1_in) mx1_in = s0_ff.mag[1];
      if (s0_ff.mag[2] > mx1_in) mx1_in = s0_ff.mag[2];
      s1_in      = s0_ff;
      s1_in.zero = (mx1_in == '0);
   end

   // shift that brings the largest into [2^30, 2^31), or no shift if bit 31 is set
   always_comb begin
      logic [SHIFT_WIDTH-1:0] msb;
      msb = '0;
      for (int i = 0; i < MAG_WIDTH - 1; i++) begin
         if (mx1_ff[i]) msb = SHIFT_WIDTH'(i);
      end
      if (mx1_ff[MAG_WIDTH-1]) k2_in = '0;
      else                     k2_in = SHIFT_WIDTH'(UNIT_BITS) - msb;
   end

   // scaled magnitudes
   always_comb begin
      s3_in = s2_ff;
      for (int i = 0; i < 3; i++) s3_in.mag[i] = s2_ff.mag[i] << k2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff   <= s0_in;
         mx1_ff  <= mx1_in;
         s1_ff   <= s1_in;
         k2_ff   <= k2_in;
         s2_ff   <= s1_ff;
         s3_ff   <= s3_in;
         for (int i = 0; i < 3; i++) sq4_ff[i] <= s3_ff.mag[i] * s3_ff.mag[i];
         s4_ff   <= s3_ff;
         sum5_ff <= sq4_ff[0] + sq4_ff[1] + sq4_ff[2];
         s5_ff   <= s4_ff;
      end
   end

   // length
   qbv_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (sum5_ff),
      .root     (root)
   );

   // side data across the root
   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= s5_ff;
         for (int j = 1; j < ISQRT_LAT; j++) sd_ff[j] <= sd_ff[j-1];
      end
   end

   // rounded numerators
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            num6_ff[i] <= (SQ_WIDTH'(sd_ff[ISQRT_LAT-1].mag[i]) << UNIT_BITS)
                          + SQ_WIDTH'(root >> 1);
         end
         den6_ff <= DEN_WIDTH'(root);
         fl6_ff  <= {sd_ff[ISQRT_LAT-1].zero, sd_ff[ISQRT_LAT-1].neg};
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      qbv_div u_div (
         .clock (clock),
         .en    (en),
         .numer (num6_ff[i]),
         .denom (den6_ff),
         .quot  (quo[i])
      );
   end

   // signs and zero flag across the division
   always_ff @(posedge clock) begin
      if (en) begin
         fd_ff[0] <= fl6_ff;
         for (int j = 1; j < DIV_LAT; j++) fd_ff[j] <= fd_ff[j-1];
      end
   end

   // restore signs
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            unit_ff[i] <= fd_ff[DIV_LAT-1][i] ? -unit_type'(quo[i]) : unit_type'(quo[i]);
         end
         zero_ff <= fd_ff[DIV_LAT-1][3];
      end
   end

   assign unit = unit_ff;
   assign zero = zero_ff;

endmodule

FILE: rtl/core/quat_between_vectors_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// req       in         req_valid / req_stall   start_x/y/z, dest_x/y/z (signed)
// rsp       out        rsp_valid / rsp_stall   quat_w/x/y/z, opposite_case, degenerate
//
// one vector pair enters per cycle unless the pipeline is frozen; on its way to
// the output each result passes through two normalizations in series,
// each a 32-stage square root and a 31-stage divider
// reset clears only the valid bits; data registers are not reset
// a held result freezes the whole pipeline, so req_stall follows rsp_stall
// while the output register is full

module quat_between_vectors_unit import qbv_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [IN_WIDTH-1:0] req_start_x,
   input  logic signed [IN_WIDTH-1:0] req_start_y,
   input  logic signed [IN_WIDTH-1:0] req_start_z,
   input  logic signed [IN_WIDTH-1:0] req_dest_x,
   input  logic signed [IN_WIDTH-1:0] req_dest_y,
   input  logic signed [IN_WIDTH-1:0] req_dest_z,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [W_WIDTH-1:0]         rsp_quat_w,
   output logic signed [C_WIDTH-1:0]  rsp_quat_x,
   output logic signed [C_WIDTH-1:0]  rsp_quat_y,
   output logic signed [C_WIDTH-1:0]  rsp_quat_z,
   output logic                       rsp_opposite_case,
   output logic                       rsp_degenerate
);

   logic                  en;
   logic                  v_ff [LAT_TOTAL];
   comp_type              a0_ff [3];
   comp_type              b0_ff [3];
   unit_type              ua [3];
   unit_type              ub [3];
   logic                  za, zb;
   logic signed [63:0]    pd1_ff [3];
   logic signed [63:0]    pc1_ff [6];
   logic signed [63:0]    pl1_ff [2];
   unit_type              u1_ff [3];
   unit_type              u2_ff [3];
   logic                  dg1_ff, dg2_ff;
   logic signed [63:0]    dot2_ff;
   logic [63:0]           len2_ff;
   cross_type             cr2_ff, cr3_ff;
   unit_type              cs3_ff, cs3_in;
   comp_type              ax3_ff [3];
   comp_type              ax3_in [3];
   flag_type              fl3_ff, fl3_in;
   flag_type              fl_ff [LAT_BRANCH];
   logic [63:0]           onepc;
   logic [ROOT_WIDTH-1:0] nroot;
   cross_type             crd_ff [ISQRT_LAT];
   logic [SQ_WIDTH-1:0]   nnum_ff [3];
   logic [DEN_WIDTH-1:0]  nden_ff;
   norm_side_type         nside_ff, nside_in;
   norm_side_type         nsd_ff [DIV_LAT];
   logic [QUO_WIDTH-1:0]  nquo [3];
   quat_type              nq_ff, nq_in;
   quat_type              npad_ff [PAD_NORM];
   unit_type              an [3];
   logic                  an_zero;
   quat_type              oq_ff, oq_in;
   quat_type              rq_ff, rq_in;
   logic                  rsp_valid_ff;
   logic                  opp_ff, degen_ff;

   // pipeline advances unless a result is held
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LAT_TOTAL; j++) v_ff[j] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int j = 1; j < LAT_TOTAL; j++) v_ff[j] <= v_ff[j-1];
         rsp_valid_ff <= v_ff[LAT_TOTAL-1];
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff[0] <= comp_type'(req_start_x);
         a0_ff[1] <= comp_type'(req_start_y);
         a0_ff[2] <= comp_type'(req_start_z);
         b0_ff[0] <= comp_type'(req_dest_x);
         b0_ff[1] <= comp_type'(req_dest_y);
         b0_ff[2] <= comp_type'(req_dest_z);
      end
   end

   qbv_unitize u_unit_start (
      .clock (clock),
      .en    (en),
      .comp  (a0_ff),
      .unit  (ua),
      .zero  (za)
   );

   qbv_unitize u_unit_dest (
      .clock (clock),
      .en    (en),
      .comp  (b0_ff),
      .unit  (ub),
      .zero  (zb)
   );

   // products, then dot, cross and axis length
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) pd1_ff[i] <= ua[i] * ub[i];
         pc1_ff[0] <= ua[1] * ub[2];
         pc1_ff[1] <= ua[2] * ub[1];
         pc1_ff[2] <= ua[2] * ub[0];
         pc1_ff[3] <= ua[0] * ub[2];
         pc1_ff[4] <= ua[0] * ub[1];
         pc1_ff[5] <= ua[1] * ub[0];
         pl1_ff[0] <= ua[0] * ua[0];
         pl1_ff[1] <= ua[1] * ua[1];
         u1_ff     <= ua;
         dg1_ff    <= za || zb;

         dot2_ff   <= pd1_ff[0] + pd1_ff[1] + pd1_ff[2];
         cr2_ff[0] <= 64'(pc1_ff[0] - pc1_ff[1]);
         cr2_ff[1] <= 64'(pc1_ff[2] - pc1_ff[3]);
         cr2_ff[2] <= 64'(pc1_ff[4] - pc1_ff[5]);
         len2_ff   <= 64'(pl1_ff[0] + pl1_ff[1]);
         u2_ff     <= u1_ff;
         dg2_ff    <= dg1_ff;
      end
   end

   // cosine, opposite test and fallback axis
   always_comb begin
      logic [63:0] dmag;
      logic [33:0] q;
      logic [31:0] qs;
      dmag = dot2_ff < 0 ? 64'(-dot2_ff) : 64'(dot2_ff);
      q    = 34'((dmag + COS_HALF) >> UNIT_BITS);
      qs   = (q > 34'(UNIT_ONE)) ? 32'(UNIT_ONE) : 32'(q);
      cs3_in       = dot2_ff < 0 ? -unit_type'(qs) : unit_type'(qs);
      fl3_in.opp   = !dg2_ff && (dot2_ff < 0) && (64'(qs) > UNIT_ONE - OPP_MARGIN);
      fl3_in.degen = dg2_ff;
      if (len2_ff < AXIS_MIN_LEN2) begin
         ax3_in[0] = '0;
         ax3_in[1] = -comp_type'(u2_ff[2]);
         ax3_in[2] = comp_type'(u2_ff[1]);
      end else begin
         ax3_in[0] = -comp_type'(u2_ff[1]);
         ax3_in[1] = comp_type'(u2_ff[0]);
         ax3_in[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cs3_ff <= cs3_in;
         fl3_ff <= fl3_in;
         ax3_ff <= ax3_in;
         cr3_ff <= cr2_ff;
      end
   end

   // flags across the branches
   always_ff @(posedge clock) begin
      if (en) begin
         fl_ff[0] <= fl3_ff;
         for (int j = 1; j < LAT_BRANCH; j++) fl_ff[j] <= fl_ff[j-1];
      end
   end

   // opposite branch: normalized axis
   qbv_unitize u_unit_axis (
      .clock (clock),
      .en    (en),
      .comp  (ax3_ff),
      .unit  (an),
      .zero  (an_zero)
   );

   always_comb begin
      logic [31:0] amag;
      logic [31:0] aq;
      oq_in   = '0;
      for (int i = 0; i < 3; i++) begin
         amag = an[i] < 0 ? 32'(-an[i]) : 32'(an[i]);
         aq   = (amag + OPP_HALF) >> DEN_SHIFT;
         if (aq > SAT_LIM) aq = SAT_LIM;
         if (an_zero) aq = '0;
         oq_in.c[i] = an[i] < 0 ? -C_WIDTH'(aq) : C_WIDTH'(aq);
      end
   end

   always_ff @(posedge clock) begin
      if (en) oq_ff <= oq_in;
   end

   // usual branch: s = sqrt(2(1 + cos))
   assign onepc = UNIT_ONE + 64'(cs3_ff);

   qbv_isqrt u_isqrt_s (
      .clock    (clock),
      .en       (en),
      .radicand (onepc << (UNIT_BITS + 1)),
      .root     (nroot)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         crd_ff[0] <= cr3_ff;
         for (int j = 1; j < ISQRT_LAT; j++) crd_ff[j] <= crd_ff[j-1];
      end
   end

   // numerators for cross / s and the scalar part
   always_comb begin
      logic [32:0] wr;
      wr  = (33'(nroot) + W_HALF) >> W_SHIFT;
      nside_in.w = (wr > 33'(SAT_LIM)) ? W_WIDTH'(SAT_LIM) : W_WIDTH'(wr);
      for (int i = 0; i < 3; i++) nside_in.neg[i] = crd_ff[ISQRT_LAT-1][i][63];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            nnum_ff[i] <= (crd_ff[ISQRT_LAT-1][i][63] ? -crd_ff[ISQRT_LAT-1][i]
                                                      : crd_ff[ISQRT_LAT-1][i])
                          + SQ_WIDTH'((DEN_WIDTH'(nroot) << DEN_SHIFT) >> 1);
         end
         nden_ff  <= DEN_WIDTH'(nroot) << DEN_SHIFT;
         nside_ff <= nside_in;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_cross_div
      qbv_div u_div (
         .clock (clock),
         .en    (en),
         .numer (nnum_ff[i]),
         .denom (nden_ff),
         .quot  (nquo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nsd_ff[0] <= nside_ff;
         for (int j = 1; j < DIV_LAT; j++) nsd_ff[j] <= nsd_ff[j-1];
      end
   end

   // saturate and sign
   always_comb begin
      logic [QUO_WIDTH-1:0] qs;
      nq_in.w = nsd_ff[DIV_LAT-1].w;
      for (int i = 0; i < 3; i++) begin
         qs = (nquo[i] > QUO_WIDTH'(SAT_LIM)) ? QUO_WIDTH'(SAT_LIM) : nquo[i];
         nq_in.c[i] = nsd_ff[DIV_LAT-1].neg[i] ? -C_WIDTH'(qs) : C_WIDTH'(qs);
      end
   end

   // align with the opposite branch
   always_ff @(posedge clock) begin
      if (en) begin
         nq_ff      <= nq_in;
         npad_ff[0] <= nq_ff;
         for (int j = 1; j < PAD_NORM; j++) npad_ff[j] <= npad_ff[j-1];
      end
   end

   // result select
   always_comb begin
      if (fl_ff[LAT_BRANCH-1].degen)    rq_in = '0;
      else if (fl_ff[LAT_BRANCH-1].opp) rq_in = oq_ff;
      else                              rq_in = npad_ff[PAD_NORM-1];
   end

   // output register
   always_ff @(posedge clock) begin
      if (en) begin
         rq_ff    <= rq_in;
         opp_ff   <= fl_ff[LAT_BRANCH-1].opp;
         degen_ff <= fl_ff[LAT_BRANCH-1].degen;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_quat_w        = rq_ff.w;
   assign rsp_quat_x        = rq_ff.c[0];
   assign rsp_quat_y        = rq_ff.c[1];
   assign rsp_quat_z        = rq_ff.c[2];
   assign rsp_opposite_case = opp_ff;
   assign rsp_degenerate    = degen_ff;

endmodule
